// File: design/u8l_pkg.sv
// Shared constants, types and decode functions for the UTF-8 to Latin-1 folder.
package u8l_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] held_cnt_t;   // bytes held in the pending buffer, 0..3
    typedef logic [2:0] res_cnt_t;    // results waiting in the output buffer, 0..4
    typedef logic [2:0] seq_len_t;    // sequence length, 2..4

    localparam byte_t LEAD_MIN   = 8'hC0;
    localparam byte_t LEAD3_MIN  = 8'hE0;
    localparam byte_t LEAD4_MIN  = 8'hF0;
    localparam byte_t REPL_CHAR  = 8'h3F;   // '?'
    localparam logic [20:0] CP_MAX = 21'h0000FF;

    localparam seq_len_t SEQ_LEN2 = 3'd2;
    localparam seq_len_t SEQ_LEN3 = 3'd3;
    localparam seq_len_t SEQ_LEN4 = 3'd4;

    function automatic seq_len_t seq_len(input byte_t lead);
        if (lead >= LEAD4_MIN)
        begin
            return SEQ_LEN4;
        end
        else if (lead >= LEAD3_MIN)
        begin
            return SEQ_LEN3;
        end
        return SEQ_LEN2;
    endfunction

    function automatic logic is_cont(input byte_t b);
        return (b[7:6] == 2'b10);
    endfunction

    // Code point of a complete sequence folded to one Latin-1 byte.
    function automatic byte_t fold_cp(input byte_t b0, input byte_t b1, input byte_t b2,
                                      input byte_t b3, input seq_len_t len);
        logic [20:0] cp;
        case (len)
            SEQ_LEN2: cp = {10'd0, b0[4:0], b1[5:0]};
            SEQ_LEN3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            SEQ_LEN4: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default:  cp = 21'd0;
        endcase
        return (cp <= CP_MAX) ? cp[7:0] : REPL_CHAR;
    endfunction

endpackage

// File: design/u8l_in_if.sv
// Input channel: one UTF-8 byte per item with an end-of-string flag.
interface u8l_in_if;
    logic             valid;
    logic             ready;
    u8l_pkg::byte_t   in_byte;
    logic             in_end;

    modport source (output valid, output in_byte, output in_end, input ready);
    modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

// File: design/u8l_out_if.sv
// Output channel: one Latin-1 byte per item with run and string markers.
interface u8l_out_if;
    logic             valid;
    logic             ready;
    u8l_pkg::byte_t   out_byte;
    logic             run_last;
    logic             string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface

// File: design/utf8_to_latin1_folder.sv
// Top level of the UTF-8 to Latin-1 stream folder.
//
// din carries one UTF-8 byte per item, in_end marks the last byte of a string.
// dout carries the folded Latin-1 bytes; run_last flags the last byte caused
// by one input item, string_end the last byte of a string.
// A lead byte and its continuations are held (up to three bytes) until the
// sequence completes or breaks; such items emit nothing but replayed held bytes.
// An item's first result is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while each item causes at most one result and dout does not stall.
// An item that causes k results (a broken sequence replays up to four bytes)
// occupies the four-entry result buffer until all k have left; the next item can be taken
// in the cycle its last result leaves.
// Reset empties both the pending buffer and the result buffer.
// When dout stalls, the result buffer holds; din.ready is high only while the
// buffer is empty or its last result leaves in that cycle.
module utf8_to_latin1_folder (
    input  logic        clk,
    input  logic        rst_n,
    u8l_in_if.sink      din,
    u8l_out_if.source   dout
);

    u8l_pkg::byte_t     pend_reg [3];
    u8l_pkg::held_cnt_t held_reg;
    u8l_pkg::byte_t     res_reg [4];
    u8l_pkg::res_cnt_t  res_cnt_reg;
    logic               end_reg;

    u8l_pkg::byte_t     buf_v [4];
    u8l_pkg::byte_t     res_next [4];
    u8l_pkg::res_cnt_t  res_cnt_next;
    u8l_pkg::held_cnt_t held_next;
    u8l_pkg::seq_len_t  len;
    logic               restart;
    logic               append;
    logic               in_acc;
    logic               out_acc;

    assign din.ready = (res_cnt_reg == 3'd0) || ((res_cnt_reg == 3'd1) && dout.ready);
    assign in_acc    = din.valid && din.ready;
    assign out_acc   = dout.valid && dout.ready;

    assign dout.valid      = (res_cnt_reg != 3'd0);
    assign dout.out_byte   = res_reg[0];
    assign dout.run_last   = (res_cnt_reg == 3'd1);
    assign dout.string_end = (res_cnt_reg == 3'd1) && end_reg;

    // Held bytes followed by the new byte; slot 3 is only reached with three held.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            buf_v[k] = (held_reg == 2'(k)) ? din.in_byte : pend_reg[k];
        end
        buf_v[3] = din.in_byte;
    end

    always_comb
    begin
        len          = u8l_pkg::seq_len(pend_reg[0]);
        res_next     = buf_v;
        res_cnt_next = 3'd0;
        held_next    = held_reg;
        restart      = 1'b0;
        append       = 1'b0;
        if ((held_reg != 2'd0) && u8l_pkg::is_cont(din.in_byte))
        begin
            if ({1'b0, held_reg} + 3'd1 == len)
            begin
                res_next[0]  = u8l_pkg::fold_cp(buf_v[0], buf_v[1], buf_v[2], buf_v[3], len);
                res_cnt_next = 3'd1;
                held_next    = 2'd0;
            end
            else if (din.in_end)
            begin
                // string cut short: lead and continuations go out raw
                res_cnt_next = {1'b0, held_reg} + 3'd1;
                held_next    = 2'd0;
            end
            else
            begin
                append    = 1'b1;
                held_next = held_reg + 2'd1;
            end
        end
        else
        begin
            // held bytes (if any) replay raw; the new byte is emitted or starts a sequence
            if ((din.in_byte < u8l_pkg::LEAD_MIN) || din.in_end)
            begin
                res_cnt_next = {1'b0, held_reg} + 3'd1;
                held_next    = 2'd0;
            end
            else
            begin
                res_cnt_next = {1'b0, held_reg};
                restart      = 1'b1;
                held_next    = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= 2'd0;
            res_cnt_reg <= 3'd0;
        end
        else
        begin
            if (in_acc)
            begin
                held_reg    <= held_next;
                res_cnt_reg <= res_cnt_next;
            end
            else if (out_acc)
            begin
                res_cnt_reg <= res_cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            res_reg <= res_next;
            end_reg <= din.in_end;
            if (restart)
            begin
                pend_reg[0] <= din.in_byte;
            end
            for (int k = 0; k < 3; k++)
            begin
                if (append && (held_reg == 2'(k)))
                begin
                    pend_reg[k] <= din.in_byte;
                end
            end
        end
        else if (out_acc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                res_reg[k] <= res_reg[k + 1];
            end
        end
    end

endmodule

// File: design/u8l_checker.sv
// Port-level assertions for the UTF-8 to Latin-1 folder, bound to the top level.
module u8l_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_end,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       string_end
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("stalled output item changed");

    // The end of a string is always the end of a run.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string_end without run_last");

    // A new item is only taken once the previous item's results are out.
    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || (out_ready && run_last))
        else $error("item accepted over pending results");

    // The last byte of a string always produces a result.
    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_end |=> out_valid)
        else $error("string end produced no result");

endmodule

bind utf8_to_latin1_folder u8l_checker u_u8l_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (din.valid),
    .in_ready   (din.ready),
    .in_end     (din.in_end),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_byte   (dout.out_byte),
    .run_last   (dout.run_last),
    .string_end (dout.string_end)
);
